>>> design/ps2mpc_pkg.sv
`default_nettype none
package ps2mpc_pkg;

	localparam int StatusW = 8;
	localparam int ByteW = 8;
	localparam int PosW = 12;
	localparam int SizeW = 13;
	localparam int SumW = 14;

	localparam logic [1:0] REG_SCREEN_WIDTH = 2'd0;
	localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd1;

	localparam int STAT_READY_BIT = 0;
	localparam int STAT_AUX_BIT = 5;
	localparam int FLAG_SYNC_BIT = 3;
	localparam int FLAG_XSIGN_BIT = 4;
	localparam int FLAG_YSIGN_BIT = 5;
	localparam int FLAG_LEFT_BIT = 0;
	localparam int FLAG_RIGHT_BIT = 1;

	localparam logic [SizeW-1:0] EDGE_MARGIN = SizeW'(10);
	localparam logic [SizeW-1:0] WIDTH_RESET = SizeW'(1024);
	localparam logic [SizeW-1:0] HEIGHT_RESET = SizeW'(768);
	localparam logic [PosW-1:0] POS_X_RESET = PosW'(500);
	localparam logic [PosW-1:0] POS_Y_RESET = PosW'(400);

	typedef struct packed {
		logic [5:0] pad;
		logic right_button;
		logic left_button;
		logic [PosW-1:0] cursor_y;
		logic [PosW-1:0] cursor_x;
	} out_beat_t;

	// Largest cursor position for a given screen size, saturated to the position width.
	function automatic logic [PosW-1:0] limit_of(input logic [SizeW-1:0] size);
		logic [SizeW-1:0] diff;
		diff = size - EDGE_MARGIN;
		if (size < EDGE_MARGIN) begin
			limit_of = '0;
		end else if (diff[SizeW-1]) begin
			limit_of = '1;
		end else begin
			limit_of = diff[PosW-1:0];
		end
	endfunction

	// A negative position goes to zero, then anything above the limit goes to the limit.
	function automatic logic [PosW-1:0] clamp_pos(input logic [SumW-1:0] sum,
			input logic [PosW-1:0] lim);
		if (sum[SumW-1]) begin
			clamp_pos = '0;
		end else if (sum[SumW-2:0] > {1'b0, lim}) begin
			clamp_pos = lim;
		end else begin
			clamp_pos = sum[PosW-1:0];
		end
	endfunction

endpackage
`default_nettype wire

>>> design/ps2_mouse_packet_cursor_core.sv
`default_nettype none
// Channel   Direction  tdata (lowest bit up)                                   tuser/tlast
// s_axis    in         controller_status[7:0], data_byte[15:8]                 none
// m_axis    out        cursor_x[11:0], cursor_y[23:12], left_button[24],       none
//                      right_button[25], zero[31:26]
// cfg       in         cfg_index 0 screen_width, 1 screen_height, cfg_wdata    none
//
// One beat is taken every cycle unless a result stalls; a completed packet's last byte
// passes the input stage and then the output register before it shows on m_axis. The rate
// is set by the single update of phase and cursor registers per beat. A stalled result holds
// only the input stage while it is needed; beats that give no result still pass. Reset puts
// the cursor at 500, 400 and needs no clearing pass.
module ps2_mouse_packet_cursor_core
	import ps2mpc_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_axis_tvalid,
	output logic s_axis_tready,
	input wire logic [15:0] s_axis_tdata, // controller_status, data_byte
	output logic m_axis_tvalid,
	input wire logic m_axis_tready,
	output logic [31:0] m_axis_tdata, // cursor_x, cursor_y, left_button, right_button
	input wire logic cfg_we,
	input wire logic [1:0] cfg_index,
	input wire logic [SizeW-1:0] cfg_wdata
);

	localparam logic [1:0] PH_FLAGS = 2'd0;
	localparam logic [1:0] PH_DX = 2'd1;
	localparam logic [1:0] PH_DY = 2'd2;

	logic valid_s1;
	logic [StatusW-1:0] status_s1;
	logic [ByteW-1:0] byte_s1;

	logic [1:0] phase_q;
	logic [ByteW-1:0] flags_q;
	logic [ByteW-1:0] dx_q;
	logic [PosW-1:0] pos_x_q;
	logic [PosW-1:0] pos_y_q;
	logic [SizeW-1:0] width_q;
	logic [SizeW-1:0] height_q;
	out_beat_t out_q;
	logic out_valid_q;

	logic counts;
	logic emits;
	logic out_free;
	logic adv;
	logic [8:0] dx9;
	logic [8:0] dy9;
	logic [SumW-1:0] sum_x;
	logic [SumW-1:0] sum_y;
	logic [PosW-1:0] new_x;
	logic [PosW-1:0] new_y;

	assign counts = valid_s1 && status_s1[STAT_READY_BIT] && status_s1[STAT_AUX_BIT];
	assign emits = counts && (phase_q != PH_FLAGS) && (phase_q != PH_DX);
	assign out_free = !out_valid_q || m_axis_tready;
	assign adv = valid_s1 && (!emits || out_free);
	assign s_axis_tready = !valid_s1 || adv;

	assign dx9 = {flags_q[FLAG_XSIGN_BIT], dx_q};
	assign dy9 = {flags_q[FLAG_YSIGN_BIT], byte_s1};
	assign sum_x = {2'b00, pos_x_q} + {{(SumW-9){dx9[8]}}, dx9};
	assign sum_y = {2'b00, pos_y_q} - {{(SumW-9){dy9[8]}}, dy9};
	assign new_x = clamp_pos(sum_x, limit_of(width_q));
	assign new_y = clamp_pos(sum_y, limit_of(height_q));

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			status_s1 <= s_axis_tdata[StatusW-1:0];
			byte_s1 <= s_axis_tdata[StatusW+ByteW-1:StatusW];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SCREEN_WIDTH: width_q <= cfg_wdata;
				REG_SCREEN_HEIGHT: height_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_FLAGS;
			pos_x_q <= POS_X_RESET;
			pos_y_q <= POS_Y_RESET;
		end else if (adv && counts) begin
			case (phase_q)
				PH_FLAGS: begin
					if (byte_s1[FLAG_SYNC_BIT]) begin
						phase_q <= PH_DX;
					end
				end
				PH_DX: phase_q <= PH_DY;
				default: begin
					phase_q <= PH_FLAGS;
					pos_x_q <= new_x;
					pos_y_q <= new_y;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (adv && counts && phase_q == PH_FLAGS && byte_s1[FLAG_SYNC_BIT]) begin
			flags_q <= byte_s1;
		end
		if (adv && counts && phase_q == PH_DX) begin
			dx_q <= byte_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && emits) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && emits) begin
			out_q.pad <= '0;
			out_q.right_button <= flags_q[FLAG_RIGHT_BIT];
			out_q.left_button <= flags_q[FLAG_LEFT_BIT];
			out_q.cursor_y <= new_y;
			out_q.cursor_x <= new_x;
		end
	end

	a_phase_legal: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != 2'd3)
		else $error("byte phase reached an unused code");

	a_result_resyncs: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> phase_q == PH_FLAGS)
		else $error("result loaded without the packet framing returning to the first byte");

	a_stall_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (valid_s1 && out_valid_q))
		else $error("input stalled with no held beat or no pending result");

	a_beat_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> valid_s1)
		else $error("accepted beat did not reach the input stage");

endmodule
`default_nettype wire
